// File: hw/rtl/afsk_pkg.sv
// Shared types, codes and the sine table of the AFSK NRZI tone modulator.
package afsk_pkg;

  // Field and register widths
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned INDEX_W    = 9;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BITS_W     = 13;
  localparam int unsigned WORD_W     = BITS_W - 3;
  localparam int unsigned STEP_W     = 7;
  localparam int unsigned PHASE_W    = 8;
  localparam int unsigned SAMPLE_W   = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  // Default packet store depth in bytes
  localparam int unsigned PACKET_BYTES_DEF = 512;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MARK  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SPACE = 1'd1;

  // Reset values and constants
  localparam logic [STEP_W-1:0]   MARK_RESET  = 7'd7;
  localparam logic [STEP_W-1:0]   SPACE_RESET = 7'd13;
  localparam logic [SAMPLE_W-1:0] IDLE_LEVEL  = 5'h10;
  localparam logic [PHASE_W:0]    TONE_LEN    = 9'd182;
  localparam int unsigned         TONE_DEPTH  = 182;

  // One input beat as seen by the modulator core
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [BITS_W-1:0] bit_count;
    logic              baud_end;
  } item_t;

  // One sine period, 5-bit unsigned, midscale 16
  localparam logic [SAMPLE_W-1:0] SINE_ROM [TONE_DEPTH] = '{
    5'd16, 5'd16, 5'd17, 5'd17, 5'd18, 5'd18, 5'd19, 5'd19, 5'd20, 5'd20,
    5'd21, 5'd21, 5'd22, 5'd22, 5'd23, 5'd23, 5'd24, 5'd24, 5'd25, 5'd25,
    5'd25, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd28, 5'd28, 5'd28, 5'd29,
    5'd29, 5'd29, 5'd29, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd31,
    5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
    5'd31, 5'd31, 5'd31, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd29,
    5'd29, 5'd29, 5'd29, 5'd28, 5'd28, 5'd28, 5'd27, 5'd27, 5'd27, 5'd26,
    5'd26, 5'd25, 5'd25, 5'd25, 5'd24, 5'd24, 5'd23, 5'd23, 5'd22, 5'd22,
    5'd21, 5'd21, 5'd20, 5'd20, 5'd19, 5'd19, 5'd18, 5'd18, 5'd17, 5'd17,
    5'd16,
    5'd16, 5'd15, 5'd14, 5'd14, 5'd13, 5'd13, 5'd12, 5'd12, 5'd11, 5'd11,
    5'd10, 5'd10, 5'd9,  5'd9,  5'd8,  5'd8,  5'd7,  5'd7,  5'd6,  5'd6,
    5'd6,  5'd5,  5'd5,  5'd4,  5'd4,  5'd4,  5'd3,  5'd3,  5'd3,  5'd2,
    5'd2,  5'd2,  5'd2,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd2,
    5'd2,  5'd2,  5'd2,  5'd3,  5'd3,  5'd3,  5'd4,  5'd4,  5'd4,  5'd5,
    5'd5,  5'd6,  5'd6,  5'd6,  5'd7,  5'd7,  5'd8,  5'd8,  5'd9,  5'd9,
    5'd10, 5'd10, 5'd11, 5'd11, 5'd12, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14,
    5'd15
  };

endpackage

// File: hw/rtl/afsk_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module afsk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port (read returns old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/afsk_core.sv
// Modulator core: frame state, NRZI tone select, phase step, sine lookup, result register.
module afsk_core import afsk_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // accepted beat
  input  logic                accept_i,
  input  item_t               item_i,
  // configuration
  input  logic [STEP_W-1:0]   step_mark_i,
  input  logic [STEP_W-1:0]   step_space_i,
  // packet store read side
  input  logic [BYTE_W-1:0]   store_byte_i,
  output logic [WORD_W-1:0]   rd_word_o,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SAMPLE_W-1:0] out_sample_o,
  output logic                out_frame_end_o
);

  logic [BITS_W-1:0]   frame_bits_q, frame_bits_d;
  logic [BITS_W-1:0]   bit_pos_q, bit_pos_d;
  logic [BYTE_W-1:0]   shift_q, shift_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                space_q, space_d;
  logic                sending_q, sending_d;
  logic                bit_start_q, bit_start_d;

  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] sample_q, sample_d;
  logic                frame_end_q, frame_end_d;
  logic                out_load;

  logic [BYTE_W-1:0]   next_byte;
  logic [PHASE_W:0]    phase_sum;

  // Next-state logic for one accepted beat
  always_comb begin
    frame_bits_d = frame_bits_q;
    bit_pos_d    = bit_pos_q;
    shift_d      = shift_q;
    phase_d      = phase_q;
    step_d       = step_q;
    space_d      = space_q;
    sending_d    = sending_q;
    bit_start_d  = bit_start_q;
    out_load     = 1'b0;
    sample_d     = sample_q;
    frame_end_d  = frame_end_q;
    next_byte    = (bit_pos_q[2:0] == 3'd0) ? store_byte_i : (shift_q >> 1);
    phase_sum    = '0;

    if (accept_i) begin
      case (item_i.req_type)
        REQ_START: begin
          frame_bits_d = item_i.bit_count;
          bit_pos_d    = '0;
          phase_d      = '0;
          step_d       = step_mark_i;
          bit_start_d  = 1'b1;
          sending_d    = 1'b1;
        end
        REQ_TICK: begin
          if (sending_q) begin
            out_load = 1'b1;
            if (bit_pos_q == frame_bits_q) begin
              // frame done: idle level and stop
              sending_d   = 1'b0;
              sample_d    = IDLE_LEVEL;
              frame_end_d = 1'b1;
            end else begin
              // NRZI: a zero bit flips the tone
              if (bit_start_q) begin
                shift_d = next_byte;
                if (!next_byte[0]) begin
                  step_d  = space_q ? step_mark_i : step_space_i;
                  space_d = !space_q;
                end
              end
              // phase advance modulo table length
              phase_sum = {1'b0, phase_q} + {2'b0, step_d};
              if (phase_sum >= TONE_LEN) begin
                phase_sum = phase_sum - TONE_LEN;
              end
              phase_d     = phase_sum[PHASE_W-1:0];
              sample_d    = SINE_ROM[phase_d];
              frame_end_d = 1'b0;
              bit_start_d = item_i.baud_end;
              if (item_i.baud_end) begin
                bit_pos_d = bit_pos_q + 1'b1;
              end
            end
          end
        end
        default: begin
          // loads are handled at the store; unknown codes do nothing
        end
      endcase
    end
  end

  // Prefetch the byte that holds the next bit
  assign rd_word_o = bit_pos_d[BITS_W-1:3];

  // Result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bits_q <= '0;
      bit_pos_q    <= '0;
      shift_q      <= '0;
      phase_q      <= '0;
      step_q       <= MARK_RESET;
      space_q      <= 1'b0;
      sending_q    <= 1'b0;
      bit_start_q  <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      frame_bits_q <= frame_bits_d;
      bit_pos_q    <= bit_pos_d;
      shift_q      <= shift_d;
      phase_q      <= phase_d;
      step_q       <= step_d;
      space_q      <= space_d;
      sending_q    <= sending_d;
      bit_start_q  <= bit_start_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    sample_q    <= sample_d;
    frame_end_q <= frame_end_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_sample_o    = sample_q;
  assign out_frame_end_o = frame_end_q;

endmodule

// File: hw/rtl/afsk_nrzi_tone_modulator_top.sv
// Top level of the AFSK NRZI tone modulator: config registers, packet store, core.
//
// Usage: write step_mark (index 0) and step_space (index 1) on the cfg port
// while idle. Load packet bytes with load beats (req_type 0), then send a
// start beat (req_type 1) with the frame length in bits. Every tick beat
// (req_type 2) while a frame runs yields one result beat: a 5-bit sample,
// bits taken LSB first, NRZI coded (a zero bit swaps mark and space tones).
// After the last bit the next tick yields the idle level 16 with frame_end
// set, and the block stops until the next start.
// Throughput: one beat per cycle on the input while no stall holds it. A
// tick's result appears in the cycle after its acceptance, out of the
// result register. The packet byte for the next bit is prefetched from the
// store's registered read port, with a bypass for a byte written in the
// same cycle, so ticks may follow each other in consecutive cycles.
// Stall: while the result register holds an untaken result and out_stall_i
// is high, tick beats are stalled; load and start beats still pass.
// Reset: steps return to 7 and 13, the tone to mark, no frame running;
// packet store contents are undefined until written.
module afsk_nrzi_tone_modulator_top import afsk_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [STEP_W-1:0]    cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [REQ_W-1:0]     in_req_type_i,
  input  logic [INDEX_W-1:0]   in_byte_index_i,
  input  logic [BYTE_W-1:0]    in_byte_value_i,
  input  logic [BITS_W-1:0]    in_bit_count_i,
  input  logic                 in_baud_end_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SAMPLE_W-1:0]  out_sample_o,
  output logic                 out_frame_end_o
);

  localparam int unsigned AW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

  logic [STEP_W-1:0] step_mark_q, step_space_q;
  logic              accept;
  item_t             item;
  logic              store_we;
  logic [WORD_W-1:0] rd_word;
  logic [BYTE_W-1:0] ram_rdata;
  logic              fwd_q, oob_q;
  logic [BYTE_W-1:0] fwd_data_q;
  logic [BYTE_W-1:0] store_byte;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_mark_q  <= MARK_RESET;
      step_space_q <= SPACE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STEP_MARK:  step_mark_q  <= cfg_data_i;
        CFG_STEP_SPACE: step_space_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input handshake: only ticks need room in the result register
  assign in_stall_o = out_valid_o && out_stall_i && (in_req_type_i == REQ_TICK);
  assign accept     = in_valid_i && !in_stall_o;

  assign item.req_type  = in_req_type_i;
  assign item.bit_count = in_bit_count_i;
  assign item.baud_end  = in_baud_end_i;

  // Packet store write, out-of-range indexes dropped
  assign store_we = accept && (in_req_type_i == REQ_LOAD) &&
                    (32'(in_byte_index_i) < 32'(PACKET_BYTES));

  afsk_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PACKET_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (AW'(in_byte_index_i)),
    .wdata_i (in_byte_value_i),
    .raddr_i (AW'(rd_word)),
    .rdata_o (ram_rdata)
  );

  // Same-cycle write bypass and out-of-range read flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
      oob_q <= 1'b0;
    end else begin
      fwd_q <= store_we && (BITS_W'(in_byte_index_i) == BITS_W'(rd_word));
      oob_q <= 32'(rd_word) >= 32'(PACKET_BYTES);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= in_byte_value_i;
  end

  assign store_byte = oob_q ? '0 : (fwd_q ? fwd_data_q : ram_rdata);

  afsk_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .item_i          (item),
    .step_mark_i     (step_mark_q),
    .step_space_i    (step_space_q),
    .store_byte_i    (store_byte),
    .rd_word_o       (rd_word),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_sample_o    (out_sample_o),
    .out_frame_end_o (out_frame_end_o)
  );

endmodule
